[rtl/core/vector3_alu_defines.svh]
// Assertion macros shared by the vector3_alu RTL
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// same-cycle implication, disabled in reset
`define V3A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define V3A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/v3a_pkg.sv]
// Types, constants and helpers for the vector3_alu pipeline
package v3a_pkg;

  localparam int SQ_STEPS  = 32;  // one root bit per cell
  localparam int DIV_STEPS = 17;  // normalize quotient never exceeds 2^16
  localparam int SQ_REM_W  = 36;
  localparam int NUM_W     = 48;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_SUB   = 3'd1,
    ACT_CROSS = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_SCALE = 3'd4,
    ACT_LEN   = 3'd5,
    ACT_NORM  = 3'd6,
    ACT_NONE  = 3'd7
  } act_t;

  // item context carried down the chain
  typedef struct packed {
    act_t             act;
    logic [2:0][31:0] a;
    logic [2:0][31:0] res;
    logic             flag;
  } carry_t;

  typedef struct packed {
    carry_t                c;
    logic [63:0]           x;
    logic [31:0]           root;
    logic [SQ_REM_W-1:0]   rem;
  } sq_t;

  typedef struct packed {
    carry_t                      c;
    logic [31:0]                 mag;
    logic [2:0][31:0]            rem;
    logic [2:0][DIV_STEPS-1:0]   nlow;
    logic [2:0][DIV_STEPS-1:0]   q;
  } dv_t;

  localparam logic signed [64:0] Q_MAX = 65'sd2147483647;
  localparam logic signed [64:0] Q_MIN = -65'sd2147483648;

  // returns {clamped, value}
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > Q_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < Q_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

[rtl/core/v3a_front.sv]
// Front end: products, sums and rounding ahead of the root chain
module v3a_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  v3a_pkg::act_t         act,
  input  logic [2:0][31:0]      a,
  input  logic [2:0][31:0]      b,
  input  logic [31:0]           s,
  output logic                  out_v,
  output v3a_pkg::sq_t          out_sq
);

  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic signed [63:0] p_nxt [6];
  logic signed [63:0] p_r [6];
  v3a_pkg::carry_t    c1_nxt, c1_r, c2_nxt;
  logic               v1_r, v2_r;
  v3a_pkg::sq_t       sq_r;
  logic signed [64:0] d [3];
  logic signed [64:0] rd [3];
  logic [32:0]        st [3];
  logic [32:0]        sa [3];
  logic signed [32:0] ab;
  logic [63:0]        sum_nxt;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    unique case (act)
      v3a_pkg::ACT_CROSS: begin
        ma[0] = a[1]; mb[0] = b[2]; ma[1] = a[2]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[0]; ma[3] = a[0]; mb[3] = b[2];
        ma[4] = a[0]; mb[4] = b[1]; ma[5] = a[1]; mb[5] = b[0];
      end
      v3a_pkg::ACT_MUL: begin
        ma[0] = a[0]; mb[0] = b[0]; ma[2] = a[1]; mb[2] = b[1];
        ma[4] = a[2]; mb[4] = b[2];
      end
      v3a_pkg::ACT_SCALE: begin
        ma[0] = a[0]; mb[0] = s; ma[2] = a[1]; mb[2] = s;
        ma[4] = a[2]; mb[4] = s;
      end
      v3a_pkg::ACT_LEN, v3a_pkg::ACT_NORM: begin
        ma[0] = a[0]; mb[0] = a[0]; ma[2] = a[1]; mb[2] = a[1];
        ma[4] = a[2]; mb[4] = a[2];
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      p_nxt[k] = ma[k] * mb[k];
    end
    // add and subtract settle in the first stage
    c1_nxt.act  = act;
    c1_nxt.a    = a;
    c1_nxt.flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (act == v3a_pkg::ACT_SUB) begin
        ab = {a[i][31], a[i]} - {b[i][31], b[i]};
      end else begin
        ab = {a[i][31], a[i]} + {b[i][31], b[i]};
      end
      sa[i] = v3a_pkg::sat32({{32{ab[32]}}, ab});
      c1_nxt.res[i] = (act == v3a_pkg::ACT_ADD || act == v3a_pkg::ACT_SUB) ?
                      sa[i][31:0] : 32'd0;
      c1_nxt.flag = c1_nxt.flag |
                    ((act == v3a_pkg::ACT_ADD || act == v3a_pkg::ACT_SUB) & sa[i][32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
    if (en) begin
      c1_r <= c1_nxt;
      for (int k = 0; k < 6; k++) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  always_comb begin
    c2_nxt = c1_r;
    for (int i = 0; i < 3; i++) begin
      if (c1_r.act == v3a_pkg::ACT_CROSS) begin
        d[i] = {p_r[2*i][63], p_r[2*i]} - {p_r[2*i+1][63], p_r[2*i+1]};
      end else begin
        d[i] = {p_r[2*i][63], p_r[2*i]};
      end
      // halves round toward +infinity
      rd[i] = (d[i] + 65'sd32768) >>> 16;
      st[i] = v3a_pkg::sat32(rd[i]);
    end
    unique case (c1_r.act)
      v3a_pkg::ACT_CROSS, v3a_pkg::ACT_MUL, v3a_pkg::ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          c2_nxt.res[i] = st[i][31:0];
        end
        c2_nxt.flag = st[0][32] | st[1][32] | st[2][32];
      end
      default: begin
      end
    endcase
    sum_nxt = p_r[0] + p_r[2] + p_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      sq_r.c    <= c2_nxt;
      sq_r.x    <= sum_nxt;
      sq_r.root <= '0;
      sq_r.rem  <= '0;
    end
  end

  assign out_v  = v2_r;
  assign out_sq = sq_r;

endmodule

[rtl/core/v3a_sqrt_cell.sv]
// One square-root cell: settles one bit of the root
module v3a_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  v3a_pkg::sq_t in_sq,
  output logic         out_v,
  output v3a_pkg::sq_t out_sq
);

  logic [v3a_pkg::SQ_REM_W-1:0] rem_s, trial;
  v3a_pkg::sq_t                 sq_nxt, sq_r;
  logic                         v_r;

  always_comb begin
    rem_s  = {in_sq.rem[v3a_pkg::SQ_REM_W-3:0], in_sq.x[63:62]};
    trial  = {2'b00, in_sq.root, 2'b01};
    sq_nxt = in_sq;
    sq_nxt.x = {in_sq.x[61:0], 2'b00};
    if (rem_s >= trial) begin
      sq_nxt.rem  = rem_s - trial;
      sq_nxt.root = {in_sq.root[30:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_s;
      sq_nxt.root = {in_sq.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign out_v  = v_r;
  assign out_sq = sq_r;

endmodule

[rtl/core/v3a_div_cell.sv]
// One divider cell: one quotient bit for each of the three lanes
module v3a_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  v3a_pkg::dv_t in_dv,
  output logic         out_v,
  output v3a_pkg::dv_t out_dv
);

  logic [32:0]  rem_s [3];
  v3a_pkg::dv_t dv_nxt, dv_r;
  logic         v_r;

  always_comb begin
    dv_nxt = in_dv;
    for (int i = 0; i < 3; i++) begin
      rem_s[i] = {in_dv.rem[i], in_dv.nlow[i][v3a_pkg::DIV_STEPS-1]};
      dv_nxt.nlow[i] = {in_dv.nlow[i][v3a_pkg::DIV_STEPS-2:0], 1'b0};
      if (rem_s[i] >= {1'b0, in_dv.mag}) begin
        dv_nxt.rem[i] = 32'(rem_s[i] - {1'b0, in_dv.mag});
        dv_nxt.q[i]   = {in_dv.q[i][v3a_pkg::DIV_STEPS-2:0], 1'b1};
      end else begin
        dv_nxt.rem[i] = rem_s[i][31:0];
        dv_nxt.q[i]   = {in_dv.q[i][v3a_pkg::DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign out_v  = v_r;
  assign out_dv = dv_r;

endmodule

[rtl/core/vector3_alu.sv]
// Three-component Q16.16 vector unit: add, subtract, cross, product, scale, length, normalize
// Fully pipelined: one operation per clock when not stalled (two front stages for the
// 32x32 products and rounding, a chain of 32 root cells giving one bit of the length each,
// one divider set-up stage, 17 divider cells working the three normalize lanes together,
// and the output register). A stalled output freezes the whole chain, so in_tready drops
// only while a finished result is waiting and out_tready is low.
`include "vector3_alu_defines.svh"

module vector3_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
  input  logic [223:0] in_tdata,
  // action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // r_x, r_y, r_z, magnitude
  output logic [127:0] out_tdata,
  // saturated
  output logic [0:0]   out_tuser
);

  logic                en;
  logic                sq_v  [v3a_pkg::SQ_STEPS+1];
  v3a_pkg::sq_t        sq_d  [v3a_pkg::SQ_STEPS+1];
  logic                dv_v  [v3a_pkg::DIV_STEPS+1];
  v3a_pkg::dv_t        dv_d  [v3a_pkg::DIV_STEPS+1];
  v3a_pkg::dv_t        prep_nxt;
  logic [31:0]         absa [3];
  logic [v3a_pkg::NUM_W-1:0] num [3];
  logic                out_valid_r;
  logic [127:0]        out_data_r, out_data_nxt;
  logic                out_sat_r, out_sat_nxt;
  v3a_pkg::act_t       out_act_r;
  v3a_pkg::dv_t        fin;
  logic signed [32:0]  sq33 [3];
  logic [32:0]         sn [3];

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  v3a_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_tvalid && en),
    .act    (v3a_pkg::act_t'(in_tuser)),
    .a      ({in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]}),
    .b      ({in_tdata[191:160], in_tdata[159:128], in_tdata[127:96]}),
    .s      (in_tdata[223:192]),
    .out_v  (sq_v[0]),
    .out_sq (sq_d[0])
  );

  for (genvar g = 0; g < v3a_pkg::SQ_STEPS; g++) begin : g_sq
    v3a_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_v   (sq_v[g]),
      .in_sq  (sq_d[g]),
      .out_v  (sq_v[g+1]),
      .out_sq (sq_d[g+1])
    );
  end

  // divider set-up: numerator |a|*2^16 + mag/2, top bits preloaded as remainder
  always_comb begin
    prep_nxt.c   = sq_d[v3a_pkg::SQ_STEPS].c;
    prep_nxt.mag = sq_d[v3a_pkg::SQ_STEPS].root;
    for (int i = 0; i < 3; i++) begin
      absa[i] = prep_nxt.c.a[i][31] ? 32'(-prep_nxt.c.a[i]) : prep_nxt.c.a[i];
      num[i]  = {absa[i], 16'd0} + {17'd0, prep_nxt.mag[31:1]};
      prep_nxt.rem[i]  = {1'b0, num[i][v3a_pkg::NUM_W-1:v3a_pkg::DIV_STEPS]};
      prep_nxt.nlow[i] = num[i][v3a_pkg::DIV_STEPS-1:0];
      prep_nxt.q[i]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[v3a_pkg::SQ_STEPS];
    end
    if (en) begin
      dv_d[0] <= prep_nxt;
    end
  end

  for (genvar g = 0; g < v3a_pkg::DIV_STEPS; g++) begin : g_dv
    v3a_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_v   (dv_v[g]),
      .in_dv  (dv_d[g]),
      .out_v  (dv_v[g+1]),
      .out_dv (dv_d[g+1])
    );
  end

  always_comb begin
    fin          = dv_d[v3a_pkg::DIV_STEPS];
    out_sat_nxt  = fin.c.flag;
    out_data_nxt = {32'd0, fin.c.res[2], fin.c.res[1], fin.c.res[0]};
    for (int i = 0; i < 3; i++) begin
      sq33[i] = {16'd0, fin.q[i]};
      if (fin.c.a[i][31]) begin
        sq33[i] = -sq33[i];
      end
      sn[i] = v3a_pkg::sat32({{32{sq33[i][32]}}, sq33[i]});
    end
    unique case (fin.c.act)
      v3a_pkg::ACT_LEN: begin
        out_data_nxt = {fin.mag, 96'd0};
        out_sat_nxt  = 1'b0;
      end
      v3a_pkg::ACT_NORM: begin
        if (fin.mag == 32'd0) begin
          // zero length passes a through
          out_data_nxt = {32'd0, fin.c.a[2], fin.c.a[1], fin.c.a[0]};
          out_sat_nxt  = 1'b0;
        end else begin
          out_data_nxt = {fin.mag, sn[2][31:0], sn[1][31:0], sn[0][31:0]};
          out_sat_nxt  = sn[0][32] | sn[1][32] | sn[2][32];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[v3a_pkg::DIV_STEPS];
    end
    if (en) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= out_sat_nxt;
      out_act_r  <= fin.c.act;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  `V3A_ASSERT_IMP(a_len_no_vec, out_valid_r && out_act_r == v3a_pkg::ACT_LEN, out_data_r[95:0] == 96'd0 && !out_sat_r, "length result carries a vector")
  `V3A_ASSERT_IMP(a_norm_no_sat, out_valid_r && out_act_r == v3a_pkg::ACT_NORM, !out_sat_r, "normalize clamped")
  `V3A_ASSERT_IMP(a_mag_only_len, out_valid_r && out_act_r != v3a_pkg::ACT_LEN && out_act_r != v3a_pkg::ACT_NORM, out_data_r[127:96] == 32'd0, "magnitude set outside length ops")
  `V3A_ASSERT_NXT(a_chain_to_out, en && dv_v[v3a_pkg::DIV_STEPS], out_valid_r, "item lost leaving divider chain")

endmodule
